// ----- hw/rtl/asit_pkg.sv -----
// Shared control flag type for the segment intersection pipeline.
package asit_pkg;

	typedef struct packed {
		logic early;      // result known at decode, no crossing needed
		logic early_hit;
		logic invalid;
		logic ok;         // crossing is taken: the other segment is perpendicular or its span holds the level
		logic u_is_x;     // crossing coordinate is x (else y)
		logic neg;        // crossing offset is negative
	} asit_flags_t;

endpackage

// ----- hw/rtl/asit_div_cell.sv -----
// One restoring division cell: resolves one quotient bit and shifts the rest along.
module asit_div_cell #(
	parameter int N  = 16,
	parameter int SW = 160
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [N-1:0]          in_rem,
	input  logic [N-1:0]          in_lo,
	input  logic [N-1:0]          in_quo,
	input  logic [N-1:0]          in_den,
	input  asit_pkg::asit_flags_t in_flags,
	input  logic [SW-1:0]         in_side,
	output logic                  out_valid,
	output logic [N-1:0]          out_rem,
	output logic [N-1:0]          out_lo,
	output logic [N-1:0]          out_quo,
	output logic [N-1:0]          out_den,
	output asit_pkg::asit_flags_t out_flags,
	output logic [SW-1:0]         out_side
);

	logic [N:0] trial;
	logic [N:0] diff;
	logic       qbit;

	always_comb begin
		trial = {in_rem, in_lo[N-1]};
		diff  = trial - {1'b0, in_den};
		qbit  = (trial >= {1'b0, in_den});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	// Payload: no reset.
	always_ff @(posedge clk) begin
		out_rem   <= qbit ? diff[N-1:0] : trial[N-1:0];
		out_lo    <= {in_lo[N-2:0], 1'b0};
		out_quo   <= {in_quo[N-2:0], qbit};
		out_den   <= in_den;
		out_flags <= in_flags;
		out_side  <= in_side;
	end

endmodule

// ----- hw/rtl/axis_segment_intersect_test.sv -----
// Top level: axis-aligned segment intersection test with a pipelined divider chain.
//
// Usage:
//   Drive the eight endpoint coordinates and raise start. A transfer happens at
//   every rising edge where start is high and busy is low; busy is always low,
//   so a new segment pair may enter in every cycle.
//   Each pair yields exactly one result: hit and invalid are valid for one
//   cycle while done is high. Results leave in the order pairs entered.
// Path: a pair passes the input register, the operand register, the product
//   register, each division cell and the output register that drives done.
// Throughput: one pair per cycle. The figure is set by the division chain:
//   one cell per quotient bit, COORD_BITS cells, each handing its partial
//   remainder to the next cell in every cycle.
// Stages: input register, case decode and operand select, one multiplier,
//   the division cells, then rounding and bounding-box checks.
// Reset: arst_n clears every valid bit at once; no result appears until a new
//   transfer has gone through. The receiver cannot stall, so there is no
//   back-pressure anywhere in the pipe.
module axis_segment_intersect_test #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] a_start_x,
	input  logic signed [COORD_BITS-1:0] a_start_y,
	input  logic signed [COORD_BITS-1:0] a_end_x,
	input  logic signed [COORD_BITS-1:0] a_end_y,
	input  logic signed [COORD_BITS-1:0] b_start_x,
	input  logic signed [COORD_BITS-1:0] b_start_y,
	input  logic signed [COORD_BITS-1:0] b_end_x,
	input  logic signed [COORD_BITS-1:0] b_end_y,
	output logic                         done,
	output logic                         hit,
	output logic                         invalid
);

	localparam int N   = COORD_BITS;
	localparam int SW  = 10 * N;  // eight endpoints, fixed level, base coordinate
	localparam int LAT = N + 4;

	assign busy = 1'b0;

	// ---------------- stage 1: capture the pair ----------------
	logic              v_s1;
	logic signed [N-1:0] ax0_s1, ay0_s1, ax1_s1, ay1_s1;
	logic signed [N-1:0] bx0_s1, by0_s1, bx1_s1, by1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		ax0_s1 <= a_start_x;
		ay0_s1 <= a_start_y;
		ax1_s1 <= a_end_x;
		ay1_s1 <= a_end_y;
		bx0_s1 <= b_start_x;
		by0_s1 <= b_start_y;
		bx1_s1 <= b_end_x;
		by1_s1 <= b_end_y;
	end

	// ---------------- decode: pick the case and the crossing operands ----------------
	logic av, ah, bv, bh;
	logic signed [N-1:0] lvl, u1, v1, u2, v2;
	logic direct, use_cross;
	logic signed [N:0] e_d, du_d, dv_d;
	logic [N-1:0] ae, adu, adv;
	logic on_seg;
	asit_pkg::asit_flags_t fl;

	always_comb begin
		av = (ax0_s1 == ax1_s1);
		ah = (ay0_s1 == ay1_s1);
		bv = (bx0_s1 == bx1_s1);
		bh = (by0_s1 == by1_s1);

		lvl = ay0_s1;
		u1  = bx0_s1;
		v1  = by0_s1;
		u2  = bx1_s1;
		v2  = by1_s1;
		direct    = 1'b0;
		use_cross = 1'b1;
		fl = '0;

		if (av && bv) begin
			fl.early     = 1'b1;
			fl.early_hit = (ax0_s1 == bx0_s1)
				&& ((ay0_s1 <= by0_s1) || (ay0_s1 <= by1_s1)
					|| (ay1_s1 <= by0_s1) || (ay1_s1 <= by1_s1))
				&& ((by0_s1 <= ay0_s1) || (by0_s1 <= ay1_s1)
					|| (by1_s1 <= ay0_s1) || (by1_s1 <= ay1_s1));
			use_cross = 1'b0;
		end else if (ah && bh) begin
			fl.early     = 1'b1;
			fl.early_hit = (ay0_s1 == by0_s1)
				&& ((ax0_s1 <= bx0_s1) || (ax0_s1 <= bx1_s1)
					|| (ax1_s1 <= bx0_s1) || (ax1_s1 <= bx1_s1))
				&& ((bx0_s1 <= ax0_s1) || (bx0_s1 <= ax1_s1)
					|| (bx1_s1 <= ax0_s1) || (bx1_s1 <= ax1_s1));
			use_cross = 1'b0;
		end else if (ah) begin
			fl.u_is_x = 1'b1;
			lvl = ay0_s1;
			u1 = bx0_s1; v1 = by0_s1; u2 = bx1_s1; v2 = by1_s1;
			direct = bv;
		end else if (bh) begin
			fl.u_is_x = 1'b1;
			lvl = by0_s1;
			u1 = ax0_s1; v1 = ay0_s1; u2 = ax1_s1; v2 = ay1_s1;
			direct = av;
		end else if (av) begin
			lvl = ax0_s1;
			u1 = by0_s1; v1 = bx0_s1; u2 = by1_s1; v2 = bx1_s1;
		end else if (bv) begin
			lvl = bx0_s1;
			u1 = ay0_s1; v1 = ax0_s1; u2 = ay1_s1; v2 = ax1_s1;
		end else begin
			fl.early   = 1'b1;
			fl.invalid = 1'b1;
			use_cross  = 1'b0;
		end

		on_seg = (((v1 <= lvl) && (lvl <= v2)) || ((v2 <= lvl) && (lvl <= v1)))
			&& (v1 != v2);
		fl.ok = use_cross && (direct || on_seg);

		e_d  = {lvl[N-1], lvl} - {v1[N-1], v1};
		du_d = {u2[N-1], u2} - {u1[N-1], u1};
		dv_d = {v2[N-1], v2} - {v1[N-1], v1};
		fl.neg = e_d[N] ^ du_d[N] ^ dv_d[N];

		// Differences of two N-bit values stay below 2^N in magnitude.
		ae  = e_d[N]  ? N'(-e_d)  : e_d[N-1:0];
		adu = du_d[N] ? N'(-du_d) : du_d[N-1:0];
		adv = dv_d[N] ? N'(-dv_d) : dv_d[N-1:0];

		// Zero offset and unit divisor where no real crossing is taken.
		if (!fl.ok || direct) begin
			ae  = '0;
			adv = N'(1);
		end
	end

	// ---------------- stage 2: operands ----------------
	logic                  v_s2;
	asit_pkg::asit_flags_t fl_s2;
	logic [N-1:0]          ae_s2, adu_s2, adv_s2;
	logic [SW-1:0]         side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		fl_s2   <= fl;
		ae_s2   <= ae;
		adu_s2  <= adu;
		adv_s2  <= adv;
		side_s2 <= {u1, lvl, ax0_s1, ay0_s1, ax1_s1, ay1_s1,
			bx0_s1, by0_s1, bx1_s1, by1_s1};
	end

	// ---------------- stage 3: product ----------------
	logic                  v_s3;
	asit_pkg::asit_flags_t fl_s3;
	logic [2*N-1:0]        prod_s3;
	logic [N-1:0]          adv_s3;
	logic [SW-1:0]         side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		fl_s3   <= fl_s2;
		prod_s3 <= ae_s2 * adu_s2;
		adv_s3  <= adv_s2;
		side_s3 <= side_s2;
	end

	// ---------------- division chain: one cell per quotient bit ----------------
	// The quotient never exceeds |du| < 2^N, so the top half of the product is
	// already below the divisor and seeds the partial remainder.
	logic                  cv    [N+1];
	logic [N-1:0]          crem  [N+1];
	logic [N-1:0]          clo   [N+1];
	logic [N-1:0]          cquo  [N+1];
	logic [N-1:0]          cden  [N+1];
	asit_pkg::asit_flags_t cfl   [N+1];
	logic [SW-1:0]         cside [N+1];

	assign cv[0]    = v_s3;
	assign crem[0]  = prod_s3[2*N-1:N];
	assign clo[0]   = prod_s3[N-1:0];
	assign cquo[0]  = '0;
	assign cden[0]  = adv_s3;
	assign cfl[0]   = fl_s3;
	assign cside[0] = side_s3;

	for (genvar g = 0; g < N; g++) begin : g_cell
		asit_div_cell #(.N(N), .SW(SW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[g]),
			.in_rem    (crem[g]),
			.in_lo     (clo[g]),
			.in_quo    (cquo[g]),
			.in_den    (cden[g]),
			.in_flags  (cfl[g]),
			.in_side   (cside[g]),
			.out_valid (cv[g+1]),
			.out_rem   (crem[g+1]),
			.out_lo    (clo[g+1]),
			.out_quo   (cquo[g+1]),
			.out_den   (cden[g+1]),
			.out_flags (cfl[g+1]),
			.out_side  (cside[g+1])
		);
	end

	// ---------------- final: round half away from zero, check boxes ----------------
	localparam int BW = N + 3;
	asit_pkg::asit_flags_t ff;
	logic [N-1:0]  q, r0, den;
	logic [N-1:0]  r;
	logic signed [N-1:0] fu1, flvl;
	logic signed [N-1:0] fax0, fay0, fax1, fay1, fbx0, fby0, fbx1, fby1;
	logic signed [BW-1:0] base, px, py;
	logic [N:0]    r2;
	logic          box_a, box_b, hit_d;

	function automatic logic betw(input logic signed [BW-1:0] v,
		input logic signed [N-1:0] e1, input logic signed [N-1:0] e2);
		logic signed [BW-1:0] x1;
		logic signed [BW-1:0] x2;
		x1 = {{3{e1[N-1]}}, e1};
		x2 = {{3{e2[N-1]}}, e2};
		return ((x1 <= v) && (v <= x2)) || ((x2 <= v) && (v <= x1));
	endfunction

	always_comb begin
		ff  = cfl[N];
		q   = cquo[N];
		r0  = crem[N];
		den = cden[N];
		{fu1, flvl, fax0, fay0, fax1, fay1, fbx0, fby0, fbx1, fby1} = cside[N];

		r = r0;
		if (!ff.neg) begin
			base = {{3{fu1[N-1]}}, fu1} + BW'(q);
		end else begin
			base = {{3{fu1[N-1]}}, fu1} - BW'(q);
			if (r0 != '0) begin
				base = base - BW'(1);
				r    = den - r0;
			end
		end
		r2 = {r, 1'b0};
		if (!base[BW-1]) begin
			base = base + BW'((r2 >= {1'b0, den}) && (r != '0));
		end else begin
			base = base + BW'(r2 > {1'b0, den});
		end

		if (ff.u_is_x) begin
			px = base;
			py = {{3{flvl[N-1]}}, flvl};
		end else begin
			px = {{3{flvl[N-1]}}, flvl};
			py = base;
		end

		box_a = betw(px, fax0, fax1) && betw(py, fay0, fay1);
		box_b = betw(px, fbx0, fbx1) && betw(py, fby0, fby1);
		hit_d = ff.early ? ff.early_hit : (ff.ok && box_a && box_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cv[N];
		end
	end

	always_ff @(posedge clk) begin
		hit     <= hit_d;
		invalid <= ff.invalid;
	end

	// ---------------- checks ----------------
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching transfer");

	a_invalid_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && invalid |-> !hit)
		else $error("invalid pair reported as hit");

	a_chain_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		cv[N] |=> done)
		else $error("division chain output dropped");

endmodule
